// File: src/pdf_pkg.sv
package pdf_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned REG_W    = 4;
  localparam int unsigned ICODE_W  = 4;
  localparam int unsigned REGS_W   = 8;
  localparam int unsigned HZ_W     = 13;
  localparam int unsigned RF_DEPTH = 15;

  // Register ids
  localparam logic [REG_W-1:0] RNONE = 4'hF;
  localparam logic [REG_W-1:0] RSP   = 4'h4;

  // Instruction codes
  localparam logic [ICODE_W-1:0] IC_RRMOVQ = 4'h2;
  localparam logic [ICODE_W-1:0] IC_IRMOVQ = 4'h3;
  localparam logic [ICODE_W-1:0] IC_RMMOVQ = 4'h4;
  localparam logic [ICODE_W-1:0] IC_MRMOVQ = 4'h5;
  localparam logic [ICODE_W-1:0] IC_OPQ    = 4'h6;
  localparam logic [ICODE_W-1:0] IC_JXX    = 4'h7;
  localparam logic [ICODE_W-1:0] IC_CALL   = 4'h8;
  localparam logic [ICODE_W-1:0] IC_RET    = 4'h9;
  localparam logic [ICODE_W-1:0] IC_PUSHQ  = 4'hA;
  localparam logic [ICODE_W-1:0] IC_POPQ   = 4'hB;

  typedef struct packed {
    logic [ICODE_W-1:0] dec_icode;
    logic [REGS_W-1:0]  dec_regs;
    logic [DATA_W-1:0]  dec_next_pc;
    logic [REG_W-1:0]   ex_dest;
    logic [DATA_W-1:0]  ex_result;
    logic [REGS_W-1:0]  mem_dests;
    logic [DATA_W-1:0]  mem_load_value;
    logic [DATA_W-1:0]  mem_alu_value;
    logic [REGS_W-1:0]  wb_dests;
    logic [DATA_W-1:0]  wb_load_value;
    logic [DATA_W-1:0]  wb_alu_value;
    logic [HZ_W-1:0]    hazard_info;
  } in_item_t;

  // Decode results; a_hit/b_hit mean the value is final and the
  // register file is not consulted.
  typedef struct packed {
    logic [REG_W-1:0]  src_a_id;
    logic [REG_W-1:0]  src_b_id;
    logic [REG_W-1:0]  alu_dest_id;
    logic [REG_W-1:0]  load_dest_id;
    logic              stall_decode;
    logic              bubble_execute;
    logic              a_hit;
    logic [DATA_W-1:0] a_val;
    logic              b_hit;
    logic [DATA_W-1:0] b_val;
  } dec_t;

  // Write-back ports into the register file
  typedef struct packed {
    logic [REG_W-1:0]  alu_dest;
    logic [REG_W-1:0]  load_dest;
    logic [DATA_W-1:0] alu_value;
    logic [DATA_W-1:0] load_value;
  } rf_wr_t;

endpackage

// File: src/pdf_ifs.sv
interface pdf_in_if;
  logic                          valid;
  logic                          ready;
  logic [pdf_pkg::ICODE_W-1:0]   dec_icode;
  logic [pdf_pkg::REGS_W-1:0]    dec_regs;
  logic [pdf_pkg::DATA_W-1:0]    dec_next_pc;
  logic [pdf_pkg::REG_W-1:0]     ex_dest;
  logic [pdf_pkg::DATA_W-1:0]    ex_result;
  logic [pdf_pkg::REGS_W-1:0]    mem_dests;
  logic [pdf_pkg::DATA_W-1:0]    mem_load_value;
  logic [pdf_pkg::DATA_W-1:0]    mem_alu_value;
  logic [pdf_pkg::REGS_W-1:0]    wb_dests;
  logic [pdf_pkg::DATA_W-1:0]    wb_load_value;
  logic [pdf_pkg::DATA_W-1:0]    wb_alu_value;
  logic [pdf_pkg::HZ_W-1:0]      hazard_info;

  modport source (
    output valid, dec_icode, dec_regs, dec_next_pc, ex_dest, ex_result,
           mem_dests, mem_load_value, mem_alu_value, wb_dests,
           wb_load_value, wb_alu_value, hazard_info,
    input  ready
  );
  modport sink (
    input  valid, dec_icode, dec_regs, dec_next_pc, ex_dest, ex_result,
           mem_dests, mem_load_value, mem_alu_value, wb_dests,
           wb_load_value, wb_alu_value, hazard_info,
    output ready
  );
endinterface

interface pdf_out_if;
  logic                        valid;
  logic                        ready;
  logic [pdf_pkg::REG_W-1:0]   src_a_id;
  logic [pdf_pkg::REG_W-1:0]   src_b_id;
  logic [pdf_pkg::DATA_W-1:0]  operand_a;
  logic [pdf_pkg::DATA_W-1:0]  operand_b;
  logic [pdf_pkg::REG_W-1:0]   alu_dest_id;
  logic [pdf_pkg::REG_W-1:0]   load_dest_id;
  logic                        stall_decode;
  logic                        bubble_execute;

  modport source (
    output valid, src_a_id, src_b_id, operand_a, operand_b, alu_dest_id,
           load_dest_id, stall_decode, bubble_execute,
    input  ready
  );
  modport sink (
    input  valid, src_a_id, src_b_id, operand_a, operand_b, alu_dest_id,
           load_dest_id, stall_decode, bubble_execute,
    output ready
  );
endinterface

// File: src/pipelined_decode_forwarding_core.sv
// Channel  Dir  Handshake            Payload
// in_ch    in   valid/ready          decode fields, stage dests and values
// out_ch   out  valid/ready          source ids, operands A/B, dests, flags
//
// One transfer per clock in steady state while out_ch is ready; a result
// passes through the decode register, then the output register.
// The register-file RAM read is registered in step with the decode register.
// Synchronous active-low reset clears the pipeline valids and the register
// file's valid bits (all registers read as zero after reset).
// A stall on out_ch holds the output register; the decode register fills
// behind it and in_ch.ready drops only when both are full.
module pipelined_decode_forwarding_core (
  input  logic           clk,
  input  logic           rst_n,
  pdf_in_if.sink         in_ch,
  pdf_out_if.source      out_ch
);

  pdf_pkg::in_item_t item;
  pdf_pkg::dec_t     dec;
  pdf_pkg::rf_wr_t   rf_wr;

  // Stage 1: decoded item, waiting on the register-file read
  logic              s1_v_r;
  logic              s1_v_nxt;
  pdf_pkg::dec_t     s1_r;

  // Stage 2: output register
  logic              out_v_r;
  logic              out_v_nxt;

  logic              in_fire;
  logic              out_load;
  logic              s1_adv;
  logic [pdf_pkg::DATA_W-1:0] rf_a;
  logic [pdf_pkg::DATA_W-1:0] rf_b;

  assign item.dec_icode      = in_ch.dec_icode;
  assign item.dec_regs       = in_ch.dec_regs;
  assign item.dec_next_pc    = in_ch.dec_next_pc;
  assign item.ex_dest        = in_ch.ex_dest;
  assign item.ex_result      = in_ch.ex_result;
  assign item.mem_dests      = in_ch.mem_dests;
  assign item.mem_load_value = in_ch.mem_load_value;
  assign item.mem_alu_value  = in_ch.mem_alu_value;
  assign item.wb_dests       = in_ch.wb_dests;
  assign item.wb_load_value  = in_ch.wb_load_value;
  assign item.wb_alu_value   = in_ch.wb_alu_value;
  assign item.hazard_info    = in_ch.hazard_info;

  pdf_decode u_decode (
    .item(item),
    .dec (dec)
  );

  // Handshake: output register loads when empty or being drained.
  assign out_load    = !out_v_r || out_ch.ready;
  assign s1_adv      = s1_v_r && out_load;
  assign in_ch.ready = !s1_v_r || out_load;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Register file is read and then written back on the same transfer edge:
  // the read sees every earlier item's write-back, not this one's.
  assign rf_wr.alu_dest   = in_ch.wb_dests[7:4];
  assign rf_wr.load_dest  = in_ch.wb_dests[3:0];
  assign rf_wr.alu_value  = in_ch.wb_alu_value;
  assign rf_wr.load_value = in_ch.wb_load_value;

  pdf_regfile u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_addr_a(dec.src_a_id),
    .rd_addr_b(dec.src_b_id),
    .wr_en    (in_fire),
    .wr       (rf_wr),
    .rd_data_a(rf_a),
    .rd_data_b(rf_b)
  );

  always_comb begin
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end

    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= dec;
    end
  end

  // Output payload: next PC (call/jump, A only) or a forwarded value if any stage matched, else the file.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch.src_a_id       <= s1_r.src_a_id;
      out_ch.src_b_id       <= s1_r.src_b_id;
      out_ch.operand_a      <= s1_r.a_hit ? s1_r.a_val : rf_a;
      out_ch.operand_b      <= s1_r.b_hit ? s1_r.b_val : rf_b;
      out_ch.alu_dest_id    <= s1_r.alu_dest_id;
      out_ch.load_dest_id   <= s1_r.load_dest_id;
      out_ch.stall_decode   <= s1_r.stall_decode;
      out_ch.bubble_execute <= s1_r.bubble_execute;
    end
  end

  assign out_ch.valid = out_v_r;

  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_v_r && (out_ch.src_a_id == $past(s1_r.src_a_id)))
    else $error("decode register did not move into the output register");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !out_load |=> s1_v_r && $stable(s1_r))
    else $error("decode register lost or changed a held item");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_r.a_hit && (s1_r.src_a_id == pdf_pkg::RNONE) |=> out_ch.operand_a == '0)
    else $error("unforwarded read of no register is not zero");

endmodule

// File: src/pdf_ram.sv
module pdf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/pdf_decode.sv
module pdf_decode (
  input  pdf_pkg::in_item_t item,
  output pdf_pkg::dec_t     dec
);

  logic [pdf_pkg::ICODE_W-1:0] ic;
  logic [pdf_pkg::REG_W-1:0]   ra;
  logic [pdf_pkg::REG_W-1:0]   rb;
  logic [pdf_pkg::REG_W-1:0]   m_dste;
  logic [pdf_pkg::REG_W-1:0]   m_dstm;
  logic [pdf_pkg::REG_W-1:0]   w_dste;
  logic [pdf_pkg::REG_W-1:0]   w_dstm;
  logic [pdf_pkg::ICODE_W-1:0] e_ic;
  logic [pdf_pkg::REG_W-1:0]   e_dstm;
  logic                        e_cnd;
  logic [pdf_pkg::ICODE_W-1:0] m_ic;
  logic [pdf_pkg::REG_W-1:0]   sa;
  logic [pdf_pkg::REG_W-1:0]   sb;
  logic                        load_use;

  assign ic     = item.dec_icode;
  assign ra     = item.dec_regs[7:4];
  assign rb     = item.dec_regs[3:0];
  assign m_dste = item.mem_dests[7:4];
  assign m_dstm = item.mem_dests[3:0];
  assign w_dste = item.wb_dests[7:4];
  assign w_dstm = item.wb_dests[3:0];
  assign e_ic   = item.hazard_info[3:0];
  assign e_dstm = item.hazard_info[7:4];
  assign e_cnd  = item.hazard_info[8];
  assign m_ic   = item.hazard_info[12:9];

  always_comb begin
    if (ic == pdf_pkg::IC_RRMOVQ || ic == pdf_pkg::IC_RMMOVQ ||
        ic == pdf_pkg::IC_OPQ || ic == pdf_pkg::IC_PUSHQ) begin
      sa = ra;
    end else if (ic == pdf_pkg::IC_POPQ || ic == pdf_pkg::IC_RET) begin
      sa = pdf_pkg::RSP;
    end else begin
      sa = pdf_pkg::RNONE;
    end

    if (ic == pdf_pkg::IC_MRMOVQ || ic == pdf_pkg::IC_RMMOVQ || ic == pdf_pkg::IC_OPQ) begin
      sb = rb;
    end else if (ic == pdf_pkg::IC_PUSHQ || ic == pdf_pkg::IC_POPQ ||
                 ic == pdf_pkg::IC_CALL || ic == pdf_pkg::IC_RET) begin
      sb = pdf_pkg::RSP;
    end else begin
      sb = pdf_pkg::RNONE;
    end
  end

  always_comb begin
    dec.src_a_id = sa;
    dec.src_b_id = sb;

    if (ic == pdf_pkg::IC_RRMOVQ || ic == pdf_pkg::IC_IRMOVQ || ic == pdf_pkg::IC_OPQ) begin
      dec.alu_dest_id = rb;
    end else if (ic == pdf_pkg::IC_PUSHQ || ic == pdf_pkg::IC_POPQ ||
                 ic == pdf_pkg::IC_CALL || ic == pdf_pkg::IC_RET) begin
      dec.alu_dest_id = pdf_pkg::RSP;
    end else begin
      dec.alu_dest_id = pdf_pkg::RNONE;
    end

    dec.load_dest_id = (ic == pdf_pkg::IC_MRMOVQ || ic == pdf_pkg::IC_POPQ) ?
                       ra : pdf_pkg::RNONE;

    // Forwarding: youngest stage first; an id of none still compares.
    dec.a_hit = 1'b1;
    priority if (ic == pdf_pkg::IC_CALL || ic == pdf_pkg::IC_JXX) begin
      dec.a_val = item.dec_next_pc;
    end else if (sa == item.ex_dest) begin
      dec.a_val = item.ex_result;
    end else if (sa == m_dstm) begin
      dec.a_val = item.mem_load_value;
    end else if (sa == m_dste) begin
      dec.a_val = item.mem_alu_value;
    end else if (sa == w_dstm) begin
      dec.a_val = item.wb_load_value;
    end else if (sa == w_dste) begin
      dec.a_val = item.wb_alu_value;
    end else begin
      dec.a_hit = 1'b0;
      dec.a_val = '0;
    end

    dec.b_hit = 1'b1;
    priority if (sb == item.ex_dest) begin
      dec.b_val = item.ex_result;
    end else if (sb == m_dstm) begin
      dec.b_val = item.mem_load_value;
    end else if (sb == m_dste) begin
      dec.b_val = item.mem_alu_value;
    end else if (sb == w_dstm) begin
      dec.b_val = item.wb_load_value;
    end else if (sb == w_dste) begin
      dec.b_val = item.wb_alu_value;
    end else begin
      dec.b_hit = 1'b0;
      dec.b_val = '0;
    end

    load_use = (e_ic == pdf_pkg::IC_MRMOVQ || e_ic == pdf_pkg::IC_POPQ) &&
               (e_dstm == sa || e_dstm == sb);
    dec.stall_decode   = load_use;
    dec.bubble_execute = (e_ic == pdf_pkg::IC_JXX && !e_cnd) ||
                         (!load_use && (ic == pdf_pkg::IC_RET ||
                                        e_ic == pdf_pkg::IC_RET ||
                                        m_ic == pdf_pkg::IC_RET));
  end

endmodule

// File: src/pdf_regfile.sv
module pdf_regfile (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [pdf_pkg::REG_W-1:0]   rd_addr_a,
  input  logic [pdf_pkg::REG_W-1:0]   rd_addr_b,
  input  logic                        wr_en,
  input  pdf_pkg::rf_wr_t             wr,
  output logic [pdf_pkg::DATA_W-1:0]  rd_data_a,
  output logic [pdf_pkg::DATA_W-1:0]  rd_data_b
);

  // Two write ports: one bank per port, each duplicated for the two read
  // ports. lvt_r marks which bank holds the live copy (1 = load bank).
  logic [pdf_pkg::RF_DEPTH-1:0] valid_r;
  logic [pdf_pkg::RF_DEPTH-1:0] valid_nxt;
  logic [pdf_pkg::RF_DEPTH-1:0] lvt_r;
  logic [pdf_pkg::RF_DEPTH-1:0] lvt_nxt;
  logic                         ok_a_r;
  logic                         ok_b_r;
  logic                         sel_a_r;
  logic                         sel_b_r;
  logic                         we_alu;
  logic                         we_load;
  logic [pdf_pkg::DATA_W-1:0]   e_rd_a;
  logic [pdf_pkg::DATA_W-1:0]   e_rd_b;
  logic [pdf_pkg::DATA_W-1:0]   m_rd_a;
  logic [pdf_pkg::DATA_W-1:0]   m_rd_b;

  assign we_alu  = wr_en && (wr.alu_dest != pdf_pkg::RNONE);
  assign we_load = wr_en && (wr.load_dest != pdf_pkg::RNONE);

  always_comb begin
    valid_nxt = valid_r;
    lvt_nxt   = lvt_r;
    if (we_alu) begin
      valid_nxt[wr.alu_dest] = 1'b1;
      lvt_nxt[wr.alu_dest]   = 1'b0;
    end
    // load port wins on the same id
    if (we_load) begin
      valid_nxt[wr.load_dest] = 1'b1;
      lvt_nxt[wr.load_dest]   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      lvt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      lvt_r   <= lvt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ok_a_r  <= (rd_addr_a != pdf_pkg::RNONE) && valid_r[rd_addr_a];
      ok_b_r  <= (rd_addr_b != pdf_pkg::RNONE) && valid_r[rd_addr_b];
      sel_a_r <= (rd_addr_a != pdf_pkg::RNONE) && lvt_r[rd_addr_a];
      sel_b_r <= (rd_addr_b != pdf_pkg::RNONE) && lvt_r[rd_addr_b];
    end
  end

  pdf_ram #(.WIDTH(pdf_pkg::DATA_W), .DEPTH(pdf_pkg::RF_DEPTH)) u_ram_e_a (
    .clk(clk), .we(we_alu), .waddr(wr.alu_dest), .wdata(wr.alu_value),
    .re(rd_en), .raddr(rd_addr_a), .rdata(e_rd_a)
  );
  pdf_ram #(.WIDTH(pdf_pkg::DATA_W), .DEPTH(pdf_pkg::RF_DEPTH)) u_ram_e_b (
    .clk(clk), .we(we_alu), .waddr(wr.alu_dest), .wdata(wr.alu_value),
    .re(rd_en), .raddr(rd_addr_b), .rdata(e_rd_b)
  );
  pdf_ram #(.WIDTH(pdf_pkg::DATA_W), .DEPTH(pdf_pkg::RF_DEPTH)) u_ram_m_a (
    .clk(clk), .we(we_load), .waddr(wr.load_dest), .wdata(wr.load_value),
    .re(rd_en), .raddr(rd_addr_a), .rdata(m_rd_a)
  );
  pdf_ram #(.WIDTH(pdf_pkg::DATA_W), .DEPTH(pdf_pkg::RF_DEPTH)) u_ram_m_b (
    .clk(clk), .we(we_load), .waddr(wr.load_dest), .wdata(wr.load_value),
    .re(rd_en), .raddr(rd_addr_b), .rdata(m_rd_b)
  );

  assign rd_data_a = !ok_a_r ? '0 : (sel_a_r ? m_rd_a : e_rd_a);
  assign rd_data_b = !ok_b_r ? '0 : (sel_b_r ? m_rd_b : e_rd_b);

  a_load_wins: assert property (@(posedge clk) disable iff (!rst_n)
    we_load && we_alu && (wr.alu_dest == wr.load_dest) |=> lvt_r[$past(wr.load_dest)])
    else $error("same-id write-back did not keep the load value");

  a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
    we_alu |=> valid_r[$past(wr.alu_dest)])
    else $error("written register not marked valid");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

  // Expected decode outcome for one instruction
  typedef struct packed {
    logic [pdf_pkg::REG_W-1:0]  src_a;
    logic [pdf_pkg::REG_W-1:0]  src_b;
    logic [pdf_pkg::DATA_W-1:0] opnd_a;
    logic [pdf_pkg::DATA_W-1:0] opnd_b;
    logic [pdf_pkg::REG_W-1:0]  alu_dst;
    logic [pdf_pkg::REG_W-1:0]  load_dst;
    logic                       stall;
    logic                       bubble;
  } decode_result_t;

  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int IDLE_LIMIT   = 2000;  // cycles without any transfer
  localparam int DRAIN_CYCLES = 6;     // decode and output registers plus margin

  logic clk;
  logic rst_n = 1'b0;

  pdf_in_if  in_ch();
  pdf_out_if out_ch();

  pipelined_decode_forwarding_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Driven copies of the channel signals; known from time zero
  pdf_pkg::in_item_t drv_item  = '0;
  logic              drv_valid = 1'b0;
  logic              rcv_ready = 1'b0;

  assign in_ch.valid          = drv_valid;
  assign in_ch.dec_icode      = drv_item.dec_icode;
  assign in_ch.dec_regs       = drv_item.dec_regs;
  assign in_ch.dec_next_pc    = drv_item.dec_next_pc;
  assign in_ch.ex_dest        = drv_item.ex_dest;
  assign in_ch.ex_result      = drv_item.ex_result;
  assign in_ch.mem_dests      = drv_item.mem_dests;
  assign in_ch.mem_load_value = drv_item.mem_load_value;
  assign in_ch.mem_alu_value  = drv_item.mem_alu_value;
  assign in_ch.wb_dests       = drv_item.wb_dests;
  assign in_ch.wb_load_value  = drv_item.wb_load_value;
  assign in_ch.wb_alu_value   = drv_item.wb_alu_value;
  assign in_ch.hazard_info    = drv_item.hazard_info;
  assign out_ch.ready         = rcv_ready;

  // Shadow register file; register fifteen is never stored
  logic [pdf_pkg::DATA_W-1:0] gpr [0:pdf_pkg::RF_DEPTH-1];

  pdf_pkg::in_item_t instr_q [$];   // instructions waiting to be offered
  decode_result_t    due_decodes [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_req     = 1'b0;
  int hold_left      = 0;

  int n_in       = 0;
  int n_checked  = 0;
  int n_stalls   = 0;
  int n_bubbles  = 0;
  int mism_cnt   = 0;
  int stray_cnt  = 0;
  int idle_cnt   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < pdf_pkg::RF_DEPTH; i++) gpr[i] = '0;
  end

  function automatic logic roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // ---------------------------------------------------------------------------
  // Decode predictor
  // ---------------------------------------------------------------------------

  // Forwarding priority: execute, memory load, memory ALU, wb load, wb ALU.
  // An id of RNONE still compares against stage destinations.
  function automatic logic [pdf_pkg::DATA_W-1:0] forward_operand(
      input logic [pdf_pkg::REG_W-1:0] id, input pdf_pkg::in_item_t it);
    if (id == it.ex_dest)             return it.ex_result;
    else if (id == it.mem_dests[3:0]) return it.mem_load_value;
    else if (id == it.mem_dests[7:4]) return it.mem_alu_value;
    else if (id == it.wb_dests[3:0])  return it.wb_load_value;
    else if (id == it.wb_dests[7:4])  return it.wb_alu_value;
    else if (id != pdf_pkg::RNONE)    return gpr[id];
    return '0;
  endfunction

  // Works out one decode result, then commits the write-back ports
  function automatic decode_result_t decode_predict(input pdf_pkg::in_item_t it);
    decode_result_t             r;
    logic [pdf_pkg::REG_W-1:0]  ra, rb, ex_ic, ex_load_dst, mem_ic;
    logic                       taken, load_use;
    ra          = it.dec_regs[7:4];
    rb          = it.dec_regs[3:0];
    ex_ic       = it.hazard_info[3:0];
    ex_load_dst = it.hazard_info[7:4];
    taken       = it.hazard_info[8];
    mem_ic      = it.hazard_info[12:9];

    unique case (it.dec_icode)
      pdf_pkg::IC_RRMOVQ, pdf_pkg::IC_RMMOVQ, pdf_pkg::IC_OPQ, pdf_pkg::IC_PUSHQ:
        r.src_a = ra;
      pdf_pkg::IC_POPQ, pdf_pkg::IC_RET: r.src_a = pdf_pkg::RSP;
      default:                           r.src_a = pdf_pkg::RNONE;
    endcase
    unique case (it.dec_icode)
      pdf_pkg::IC_MRMOVQ, pdf_pkg::IC_RMMOVQ, pdf_pkg::IC_OPQ: r.src_b = rb;
      pdf_pkg::IC_PUSHQ, pdf_pkg::IC_POPQ, pdf_pkg::IC_CALL, pdf_pkg::IC_RET:
        r.src_b = pdf_pkg::RSP;
      default: r.src_b = pdf_pkg::RNONE;
    endcase
    unique case (it.dec_icode)
      pdf_pkg::IC_RRMOVQ, pdf_pkg::IC_IRMOVQ, pdf_pkg::IC_OPQ: r.alu_dst = rb;
      pdf_pkg::IC_PUSHQ, pdf_pkg::IC_POPQ, pdf_pkg::IC_CALL, pdf_pkg::IC_RET:
        r.alu_dst = pdf_pkg::RSP;
      default: r.alu_dst = pdf_pkg::RNONE;
    endcase
    r.load_dst = (it.dec_icode == pdf_pkg::IC_MRMOVQ || it.dec_icode == pdf_pkg::IC_POPQ) ?
                 ra : pdf_pkg::RNONE;

    if (it.dec_icode == pdf_pkg::IC_CALL || it.dec_icode == pdf_pkg::IC_JXX)
      r.opnd_a = it.dec_next_pc;
    else
      r.opnd_a = forward_operand(r.src_a, it);
    r.opnd_b = forward_operand(r.src_b, it);

    load_use = (ex_ic == pdf_pkg::IC_MRMOVQ || ex_ic == pdf_pkg::IC_POPQ) &&
               (ex_load_dst == r.src_a || ex_load_dst == r.src_b);
    r.stall  = load_use;
    r.bubble = (ex_ic == pdf_pkg::IC_JXX && !taken) ||
               (!load_use && (it.dec_icode == pdf_pkg::IC_RET || ex_ic == pdf_pkg::IC_RET ||
                              mem_ic == pdf_pkg::IC_RET));

    // load port written last so it wins a tie
    if (it.wb_dests[7:4] != pdf_pkg::RNONE) gpr[it.wb_dests[7:4]] = it.wb_alu_value;
    if (it.wb_dests[3:0] != pdf_pkg::RNONE) gpr[it.wb_dests[3:0]] = it.wb_load_value;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [pdf_pkg::DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Register ids skewed toward a few values so stages collide often
  function automatic logic [pdf_pkg::REG_W-1:0] pick_reg();
    case ($urandom_range(0, 4))
      0:       return pdf_pkg::RNONE;
      1:       return pdf_pkg::RSP;
      2:       return pdf_pkg::REG_W'($urandom_range(0, 3));
      default: return pdf_pkg::REG_W'($urandom_range(0, 15));
    endcase
  endfunction

  // No stage names a destination, nothing in flight
  function automatic pdf_pkg::in_item_t quiet_item(input logic [pdf_pkg::ICODE_W-1:0] ic,
                                                   input logic [pdf_pkg::REGS_W-1:0] regs);
    pdf_pkg::in_item_t it;
    it.dec_icode      = ic;
    it.dec_regs       = regs;
    it.dec_next_pc    = rand_word();
    it.ex_dest        = pdf_pkg::RNONE;
    it.ex_result      = rand_word();
    it.mem_dests      = {pdf_pkg::RNONE, pdf_pkg::RNONE};
    it.mem_load_value = rand_word();
    it.mem_alu_value  = rand_word();
    it.wb_dests       = {pdf_pkg::RNONE, pdf_pkg::RNONE};
    it.wb_load_value  = rand_word();
    it.wb_alu_value   = rand_word();
    it.hazard_info    = {4'h0, 1'b1, pdf_pkg::RNONE, 4'h0};
    return it;
  endfunction

  function automatic pdf_pkg::in_item_t rand_item();
    pdf_pkg::in_item_t         it;
    logic [pdf_pkg::REG_W-1:0] ex_ic, mem_ic;
    it = quiet_item($urandom_range(0, 3) == 0 ? pdf_pkg::ICODE_W'($urandom_range(0, 15))
                                              : pdf_pkg::ICODE_W'($urandom_range(2, 11)),
                    {pick_reg(), pick_reg()});
    it.wb_dests = {pick_reg(), pick_reg()};
    // a quarter of the time only write-back forwards, so the file gets read
    if ($urandom_range(0, 3) != 0) begin
      it.ex_dest   = pick_reg();
      it.mem_dests = {pick_reg(), pick_reg()};
    end
    case ($urandom_range(0, 5))
      0:       ex_ic = pdf_pkg::IC_MRMOVQ;
      1:       ex_ic = pdf_pkg::IC_POPQ;
      2:       ex_ic = pdf_pkg::IC_JXX;
      3:       ex_ic = pdf_pkg::IC_RET;
      default: ex_ic = pdf_pkg::REG_W'($urandom_range(0, 15));
    endcase
    mem_ic = ($urandom_range(0, 4) == 0) ? pdf_pkg::IC_RET
                                         : pdf_pkg::REG_W'($urandom_range(0, 15));
    it.hazard_info = {mem_ic, 1'($urandom_range(0, 1)), pick_reg(), ex_ic};
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers instructions from instr_q, predicts on each transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    logic              nxt_valid;
    pdf_pkg::in_item_t nxt_item;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      nxt_valid = drv_valid;
      nxt_item  = drv_item;
      if (drv_valid && in_ch.ready) begin
        decode_result_t r;
        r = decode_predict(drv_item);
        due_decodes.push_back(r);
        n_in++;
        if (r.stall)  n_stalls++;
        if (r.bubble) n_bubbles++;
        nxt_valid = 1'b0;
      end
      // a pending offer must stay up; otherwise maybe idle this cycle
      if (!nxt_valid && instr_q.size() != 0 && !roll(send_idle_pct)) begin
        nxt_item  = instr_q.pop_front();
        nxt_valid = 1'b1;
      end
      drv_valid <= nxt_valid;
      drv_item  <= nxt_item;
    end
  end

  // Long hold-off counter for the receiver
  always @(posedge clk) begin
    if (!rst_n)               hold_left <= 0;
    else if (hold_req)        hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)  hold_left <= hold_left - 1;
  end

  task automatic check_field(input string name, input logic [pdf_pkg::DATA_W-1:0] exp_v,
                             input logic [pdf_pkg::DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mism_cnt++;
      if (mism_cnt <= 10)
        $display("%0t: result %0d %s mismatch: expected %h, got %h",
                 $realtime, n_checked, name, exp_v, act_v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    decode_result_t e;
    if (!rst_n) begin
      rcv_ready <= 1'b0;
    end else begin
      if (out_ch.valid && rcv_ready) begin
        if (due_decodes.size() == 0) begin
          stray_cnt++;
          if (stray_cnt <= 10) $display("%0t: result with no instruction pending", $realtime);
        end else begin
          e = due_decodes.pop_front();
          check_field("src_a_id",       e.src_a,    out_ch.src_a_id);
          check_field("src_b_id",       e.src_b,    out_ch.src_b_id);
          check_field("operand_a",      e.opnd_a,   out_ch.operand_a);
          check_field("operand_b",      e.opnd_b,   out_ch.operand_b);
          check_field("alu_dest_id",    e.alu_dst,  out_ch.alu_dest_id);
          check_field("load_dest_id",   e.load_dst, out_ch.load_dest_id);
          check_field("stall_decode",   e.stall,    out_ch.stall_decode);
          check_field("bubble_execute", e.bubble,   out_ch.bubble_execute);
          n_checked++;
        end
      end
      rcv_ready <= (hold_left == 0) && !hold_req && !roll(recv_stall_pct);
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (drv_valid && in_ch.ready) || (out_ch.valid && rcv_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", idle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Sender pause: returns once every offered instruction has its result
  task automatic wait_drained();
    do @(negedge clk);
    while (instr_q.size() != 0 || drv_valid || due_decodes.size() != 0);
  endtask

  task automatic run_random(input int send_pct, input int recv_pct, input int count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) instr_q.push_back(rand_item());
    wait_drained();
  endtask

  initial begin
    pdf_pkg::in_item_t it;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Seed the file: reg 14 plus an ignored write to fifteen, a port tie on
    // reg 3 (load value must stick), and the stack pointer.
    it = quiet_item(4'h1, 8'hFF); it.wb_dests = {4'hE, pdf_pkg::RNONE};
    instr_q.push_back(it);
    it = quiet_item(4'h1, 8'hFF); it.wb_dests = {pdf_pkg::RNONE, 4'hE};
    it.wb_alu_value = '1;
    instr_q.push_back(it);
    it = quiet_item(4'h1, 8'hFF); it.wb_dests = {4'h3, 4'h3};
    instr_q.push_back(it);
    it = quiet_item(4'h1, 8'hFF); it.wb_dests = {pdf_pkg::RSP, 4'h5};
    instr_q.push_back(it);

    // Every instruction code, sources read from the file
    for (int ic = 0; ic < 16; ic++)
      instr_q.push_back(quiet_item(pdf_pkg::ICODE_W'(ic),
                                   {(ic[0] ? 4'hE : 4'h3), pdf_pkg::RSP}));

    // Forwarding priority on the same register, dropping one stage each time
    it = quiet_item(pdf_pkg::IC_OPQ, 8'h33);
    it.ex_dest = 4'h3; it.mem_dests = 8'h33; it.wb_dests = 8'h33;
    instr_q.push_back(it);
    it.ex_dest = pdf_pkg::RNONE;
    instr_q.push_back(it);
    it.mem_dests = {4'h3, pdf_pkg::RNONE};
    instr_q.push_back(it);

    // No source and no stage naming register fifteen: operands are zero
    it = quiet_item(pdf_pkg::IC_IRMOVQ, 8'hF0);
    it.ex_dest = 4'h0; it.mem_dests = 8'h00; it.wb_dests = 8'h00;
    instr_q.push_back(it);

    // Load/use stall with a return in memory: bubble suppressed
    it = quiet_item(pdf_pkg::IC_OPQ, 8'h12);
    it.hazard_info = {pdf_pkg::IC_RET, 1'b1, 4'h2, pdf_pkg::IC_MRMOVQ};
    instr_q.push_back(it);

    // Mispredicted jump in execute
    it = quiet_item(pdf_pkg::IC_RRMOVQ, 8'h21);
    it.hazard_info = {4'h0, 1'b0, pdf_pkg::RNONE, pdf_pkg::IC_JXX};
    instr_q.push_back(it);

    // All-ones and all-zeros extremes
    instr_q.push_back('1);
    instr_q.push_back('0);
    wait_drained();

    // Random traffic under each idling pattern
    run_random(0,  0,  180);
    run_random(82, 0,  180);
    run_random(0,  82, 180);
    run_random(17, 17, 180);

    // Back-pressure: receiver holds off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (60) instr_q.push_back(rand_item());
    hold_req = 1'b1;
    @(negedge clk);
    hold_req = 1'b0;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("decoded %0d instructions, checked %0d results (%0d load/use stalls, %0d bubbles)",
             n_in, n_checked, n_stalls, n_bubbles);
    $display("field mismatches: %0d, unexpected results: %0d", mism_cnt, stray_cnt);
    if (mism_cnt == 0 && stray_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
